// ----- hw/rtl/aalu_pkg.sv -----
`default_nettype none

package aalu_pkg;

   localparam int ActionWidth = 5;
   localparam int ByteWidth   = 8;
   localparam int WideWidth   = 16;

   localparam logic [ActionWidth-1:0] ACT_ADD    = 5'd0;
   localparam logic [ActionWidth-1:0] ACT_ADC    = 5'd1;
   localparam logic [ActionWidth-1:0] ACT_SUB    = 5'd2;
   localparam logic [ActionWidth-1:0] ACT_SBC    = 5'd3;
   localparam logic [ActionWidth-1:0] ACT_AND    = 5'd4;
   localparam logic [ActionWidth-1:0] ACT_XOR    = 5'd5;
   localparam logic [ActionWidth-1:0] ACT_OR     = 5'd6;
   localparam logic [ActionWidth-1:0] ACT_CP     = 5'd7;
   localparam logic [ActionWidth-1:0] ACT_INC    = 5'd8;
   localparam logic [ActionWidth-1:0] ACT_DEC    = 5'd9;
   localparam logic [ActionWidth-1:0] ACT_RLCA   = 5'd10;
   localparam logic [ActionWidth-1:0] ACT_RRCA   = 5'd11;
   localparam logic [ActionWidth-1:0] ACT_RLA    = 5'd12;
   localparam logic [ActionWidth-1:0] ACT_RRA    = 5'd13;
   localparam logic [ActionWidth-1:0] ACT_DAA    = 5'd14;
   localparam logic [ActionWidth-1:0] ACT_CPL    = 5'd15;
   localparam logic [ActionWidth-1:0] ACT_ADD16  = 5'd16;
   localparam logic [ActionWidth-1:0] ACT_ADDSP  = 5'd17;
   localparam logic [ActionWidth-1:0] ACT_LOAD_A = 5'd18;

   localparam logic [ByteWidth-1:0] DAA_LIMIT    = 8'h99;
   localparam logic [ByteWidth-1:0] DAA_HIGH_ADJ = 8'h60;
   localparam logic [ByteWidth-1:0] DAA_LOW_ADJ  = 8'h06;
   localparam logic [3:0]           DAA_NIBBLE_MAX = 4'h9;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   localparam flags_type FLAGS_CLEAR = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};

endpackage

`default_nettype wire

// ----- hw/rtl/aalu_exec.sv -----
`default_nettype none

module aalu_exec (
   input  wire logic [aalu_pkg::ActionWidth-1:0] action,
   input  wire logic [aalu_pkg::ByteWidth-1:0]   operand,
   input  wire logic [aalu_pkg::WideWidth-1:0]   wide_left,
   input  wire logic [aalu_pkg::WideWidth-1:0]   wide_right,
   input  wire logic [aalu_pkg::ByteWidth-1:0]   acc,
   input  wire aalu_pkg::flags_type               flags,
   output logic [aalu_pkg::ByteWidth-1:0]        acc_next,
   output logic [aalu_pkg::ByteWidth-1:0]        byte_result,
   output logic [aalu_pkg::WideWidth-1:0]        wide_result,
   output aalu_pkg::flags_type                   flags_next
);

   logic       add_cin;
   logic       sub_cin;
   logic [8:0] add_sum;
   logic [4:0] add_low;
   logic [8:0] sub_diff;
   logic [4:0] sub_low;
   logic [7:0] inc_val;
   logic [7:0] dec_val;
   logic [16:0] w16_sum;
   logic [12:0] w16_low;
   logic [15:0] sp_sum;
   logic [4:0]  sp_low;
   logic [8:0]  sp_byte;
   logic        daa_hi;
   logic [7:0]  daa_a1;
   logic [7:0]  daa_a2;
   logic [7:0]  daa_res;

   always_comb begin
      add_cin  = (action == aalu_pkg::ACT_ADC) & flags.c;
      sub_cin  = (action == aalu_pkg::ACT_SBC) & flags.c;
      add_sum  = {1'b0, acc} + {1'b0, operand} + {8'd0, add_cin};
      add_low  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, add_cin};
      sub_diff = {1'b0, acc} - {1'b0, operand} - {8'd0, sub_cin};
      sub_low  = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, sub_cin};
      inc_val  = operand + 8'd1;
      dec_val  = operand - 8'd1;
      w16_sum  = {1'b0, wide_left} + {1'b0, wide_right};
      w16_low  = {1'b0, wide_left[11:0]} + {1'b0, wide_right[11:0]};
      sp_sum   = wide_left + {{8{operand[7]}}, operand};
      sp_low   = {1'b0, wide_left[3:0]} + {1'b0, operand[3:0]};
      sp_byte  = {1'b0, wide_left[7:0]} + {1'b0, operand};

      daa_hi = flags.c | (acc > aalu_pkg::DAA_LIMIT);
      if (!flags.n) begin
         daa_a1 = daa_hi ? acc + aalu_pkg::DAA_HIGH_ADJ : acc;
         daa_a2 = (flags.h | (daa_a1[3:0] > aalu_pkg::DAA_NIBBLE_MAX))
                  ? daa_a1 + aalu_pkg::DAA_LOW_ADJ : daa_a1;
      end else begin
         daa_a1 = flags.c ? acc - aalu_pkg::DAA_HIGH_ADJ : acc;
         daa_a2 = flags.h ? daa_a1 - aalu_pkg::DAA_LOW_ADJ : daa_a1;
      end
      daa_res = daa_a2;

      acc_next    = acc;
      flags_next  = flags;
      wide_result = '0;

      case (action)
         aalu_pkg::ACT_ADD, aalu_pkg::ACT_ADC: begin
            acc_next   = add_sum[7:0];
            flags_next = '{z: (add_sum[7:0] == 8'd0), n: 1'b0,
                           h: add_low[4], c: add_sum[8]};
         end
         aalu_pkg::ACT_SUB, aalu_pkg::ACT_SBC, aalu_pkg::ACT_CP: begin
            if (action != aalu_pkg::ACT_CP) begin
               acc_next = sub_diff[7:0];
            end
            flags_next = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1,
                           h: sub_low[4], c: sub_diff[8]};
         end
         aalu_pkg::ACT_AND: begin
            acc_next   = acc & operand;
            flags_next = '{z: ((acc & operand) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         aalu_pkg::ACT_XOR: begin
            acc_next   = acc ^ operand;
            flags_next = '{z: ((acc ^ operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         aalu_pkg::ACT_OR: begin
            acc_next   = acc | operand;
            flags_next = '{z: ((acc | operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         aalu_pkg::ACT_INC: begin
            flags_next = '{z: (inc_val == 8'd0), n: 1'b0,
                           h: (operand[3:0] == 4'hF), c: flags.c};
         end
         aalu_pkg::ACT_DEC: begin
            flags_next = '{z: (dec_val == 8'd0), n: 1'b1,
                           h: (operand[3:0] == 4'h0), c: flags.c};
         end
         aalu_pkg::ACT_RLCA: begin
            acc_next   = {acc[6:0], acc[7]};
            flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
         end
         aalu_pkg::ACT_RRCA: begin
            acc_next   = {acc[0], acc[7:1]};
            flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
         end
         aalu_pkg::ACT_RLA: begin
            acc_next   = {acc[6:0], flags.c};
            flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
         end
         aalu_pkg::ACT_RRA: begin
            acc_next   = {flags.c, acc[7:1]};
            flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
         end
         aalu_pkg::ACT_DAA: begin
            acc_next   = daa_res;
            flags_next = '{z: (daa_res == 8'd0), n: flags.n, h: 1'b0,
                           c: flags.c | (~flags.n & daa_hi)};
         end
         aalu_pkg::ACT_CPL: begin
            acc_next   = ~acc;
            flags_next = '{z: flags.z, n: 1'b1, h: 1'b1, c: flags.c};
         end
         aalu_pkg::ACT_ADD16: begin
            wide_result = w16_sum[15:0];
            flags_next  = '{z: flags.z, n: 1'b0, h: w16_low[12], c: w16_sum[16]};
         end
         aalu_pkg::ACT_ADDSP: begin
            wide_result = sp_sum;
            flags_next  = '{z: 1'b0, n: 1'b0, h: sp_low[4], c: sp_byte[8]};
         end
         aalu_pkg::ACT_LOAD_A: begin
            acc_next = operand;
         end
         default: begin
            acc_next = acc;
         end
      endcase

      case (action)
         aalu_pkg::ACT_INC: byte_result = inc_val;
         aalu_pkg::ACT_DEC: byte_result = dec_val;
         default:           byte_result = acc_next;
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/accumulator_alu_with_flags_unit.sv -----
// Accumulator ALU with Z, N, H and C flags.
// Request channel (req_*): one operation code with its byte and 16-bit
// operands per request, taken when req_valid is high and req_stall low.
// Response channel (rsp_*): accumulator, byte result, 16-bit result and the
// four flags after that operation, taken when rsp_valid is high and
// rsp_stall low. Exactly one response per request, in request order.
// A request passes through the input register, then through the ALU into
// the output register.
// Throughput: one request per cycle while the receiver does not stall; the
// accumulator and flags are updated as a request leaves the input register,
// so the next request sees them at once.
// Reset (synchronous, active high) clears the accumulator, the flags and
// both stage valids.
// When the receiver stalls, the response holds; one more request can wait
// in the input register, after which req_stall rises until the response
// is taken.
`default_nettype none

module accumulator_alu_with_flags_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [aalu_pkg::ActionWidth-1:0]   req_action,
   input  wire logic [aalu_pkg::ByteWidth-1:0]     req_operand,
   input  wire logic [aalu_pkg::WideWidth-1:0]     req_wide_left,
   input  wire logic [aalu_pkg::WideWidth-1:0]     req_wide_right,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [aalu_pkg::ByteWidth-1:0]          rsp_accumulator_out,
   output logic [aalu_pkg::ByteWidth-1:0]          rsp_byte_result,
   output logic [aalu_pkg::WideWidth-1:0]          rsp_wide_result,
   output logic                                    rsp_zero_flag,
   output logic                                    rsp_subtract_flag,
   output logic                                    rsp_half_carry_flag,
   output logic                                    rsp_carry_flag
);

   logic                             in_valid_ff;
   logic [aalu_pkg::ActionWidth-1:0] action_ff;
   logic [aalu_pkg::ByteWidth-1:0]   operand_ff;
   logic [aalu_pkg::WideWidth-1:0]   wide_left_ff;
   logic [aalu_pkg::WideWidth-1:0]   wide_right_ff;

   logic [aalu_pkg::ByteWidth-1:0]   acc_ff;
   logic [aalu_pkg::ByteWidth-1:0]   acc_in;
   aalu_pkg::flags_type              flags_ff;
   aalu_pkg::flags_type              flags_in;

   logic                             out_valid_ff;
   logic [aalu_pkg::ByteWidth-1:0]   out_acc_ff;
   logic [aalu_pkg::ByteWidth-1:0]   out_byte_ff;
   logic [aalu_pkg::ByteWidth-1:0]   byte_in;
   logic [aalu_pkg::WideWidth-1:0]   out_wide_ff;
   logic [aalu_pkg::WideWidth-1:0]   wide_in;
   aalu_pkg::flags_type              out_flags_ff;

   logic out_free;
   logic advance;
   logic take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   aalu_exec u_exec (
      .action      (action_ff),
      .operand     (operand_ff),
      .wide_left   (wide_left_ff),
      .wide_right  (wide_right_ff),
      .acc         (acc_ff),
      .flags       (flags_ff),
      .acc_next    (acc_in),
      .byte_result (byte_in),
      .wide_result (wide_in),
      .flags_next  (flags_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         flags_ff     <= aalu_pkg::FLAGS_CLEAR;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            acc_ff       <= acc_in;
            flags_ff     <= flags_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         action_ff     <= req_action;
         operand_ff    <= req_operand;
         wide_left_ff  <= req_wide_left;
         wide_right_ff <= req_wide_right;
      end
      if (advance) begin
         out_acc_ff   <= acc_in;
         out_byte_ff  <= byte_in;
         out_wide_ff  <= wide_in;
         out_flags_ff <= flags_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_accumulator_out = out_acc_ff;
   assign rsp_byte_result     = out_byte_ff;
   assign rsp_wide_result     = out_wide_ff;
   assign rsp_zero_flag       = out_flags_ff.z;
   assign rsp_subtract_flag   = out_flags_ff.n;
   assign rsp_half_carry_flag = out_flags_ff.h;
   assign rsp_carry_flag      = out_flags_ff.c;

endmodule

`default_nettype wire

// ----- hw/rtl/aalu_check.sv -----
`default_nettype none

module aalu_check (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [aalu_pkg::ByteWidth-1:0]   rsp_accumulator_out,
   input wire logic [aalu_pkg::ByteWidth-1:0]   rsp_byte_result,
   input wire logic [aalu_pkg::WideWidth-1:0]   rsp_wide_result
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("request stalled while response side is free");

   a_request_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 (!rsp_valid || !rsp_stall) |=> rsp_valid)
      else $error("accepted request did not reach the response register");

   a_stalled_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accumulator_out)
         && $stable(rsp_byte_result) && $stable(rsp_wide_result))
      else $error("stalled response changed");

endmodule

bind accumulator_alu_with_flags_unit aalu_check u_aalu_check (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_accumulator_out (rsp_accumulator_out),
   .rsp_byte_result     (rsp_byte_result),
   .rsp_wide_result     (rsp_wide_result)
);

`default_nettype wire
